// File: hdl/iirdf1_pkg.sv
package iirdf1_pkg;

  localparam int unsigned TAPS_DEF  = 5;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned COEF_W    = 18;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned PROD_W    = COEF_W + SAMPLE_W;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned YW_W      = ACC_W - FRAC_BITS;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_FF  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_FB  = 2'd2;

  typedef enum logic [1:0] {
    OPND_SAMPLE,
    OPND_HIST_X,
    OPND_HIST_Y
  } opnd_e;

  typedef struct packed {
    logic  clear;
    logic  valid;
    opnd_e opnd;
    logic  coef_ok;
    logic  hist_ok;
  } mac_ctrl_t;

endpackage

// File: hdl/iirdf1_in_if.sv
interface iirdf1_in_if;
  import iirdf1_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic [IDX_W-1:0]           coef_index;
  logic signed [COEF_W-1:0]   coef_value;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       block_end;

  modport source (
    output valid, command, coef_index, coef_value, sample_in, block_end,
    input  ready
  );

  modport sink (
    input  valid, command, coef_index, coef_value, sample_in, block_end,
    output ready
  );

endinterface

// File: hdl/iirdf1_out_if.sv
interface iirdf1_out_if;
  import iirdf1_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       saturated;
  logic                       last_out;

  modport source (
    output valid, sample_out, saturated, last_out,
    input  ready
  );

  modport sink (
    input  valid, sample_out, saturated, last_out,
    output ready
  );

endinterface

// File: hdl/iirdf1_ram.sv
module iirdf1_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/iirdf1_mac.sv
module iirdf1_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  iirdf1_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [iirdf1_pkg::COEF_W-1:0]   coef_i,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] sample_i,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] hist_x_i,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] hist_y_i,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_o,
  output logic                                  sat_o
);
  import iirdf1_pkg::*;

  logic signed [COEF_W-1:0]   coef;
  logic signed [SAMPLE_W-1:0] opnd;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic                       p2_valid_q, p2_sub_q;
  logic signed [ACC_W-1:0]    acc_d, acc_q;
  logic signed [ACC_W-1:0]    rnd;
  logic signed [YW_W-1:0]     y_wide;
  logic                       in_range;

  always_comb begin
    coef = ctrl_i.coef_ok ? coef_i : '0;
    case (ctrl_i.opnd)
      OPND_SAMPLE: opnd = sample_i;
      OPND_HIST_X: opnd = ctrl_i.hist_ok ? hist_x_i : '0;
      OPND_HIST_Y: opnd = ctrl_i.hist_ok ? hist_y_i : '0;
      default:     opnd = '0;
    endcase
    prod_d = PROD_W'(coef) * PROD_W'(opnd);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
      p2_sub_q   <= 1'b0;
      acc_q      <= '0;
    end else begin
      p2_valid_q <= ctrl_i.valid;
      p2_sub_q   <= (ctrl_i.opnd == OPND_HIST_Y);
      acc_q      <= acc_d;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (p2_valid_q) begin
      if (p2_sub_q) begin
        acc_d = acc_q - ACC_W'(prod_q);
      end else begin
        acc_d = acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_comb begin
    rnd      = acc_q + ACC_W'(1 << (FRAC_BITS - 1));
    y_wide   = YW_W'(rnd >>> FRAC_BITS);
    in_range = (&y_wide[YW_W-1:SAMPLE_W-1]) || !(|y_wide[YW_W-1:SAMPLE_W-1]);
    sat_o    = !in_range;
    if (in_range) begin
      y_o = y_wide[SAMPLE_W-1:0];
    end else if (y_wide[YW_W-1]) begin
      y_o = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_o = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

// File: hdl/iir_direct_form_one_filter.sv
// Channel  Dir  Word fields
// in_i     in   command, coef_index, coef_value, sample_in, block_end
// out_o    out  sample_out, saturated, last_out (one word per sample command)
//
// A sample holds the input from the accepting cycle through one coefficient memory
// read per product through the single shared multiplier, the drain states ST_DR1 and
// ST_DR2, and the ST_DONE step that rounds and writes the history; that step also
// loads the sample's word into the output register.
// Reset clears all coefficients and history through valid bits, with no sweep.
// A finished word waits in the output register; the last step of the next sample
// holds until that register is free.
module iir_direct_form_one_filter #(
  parameter int unsigned TAPS = iirdf1_pkg::TAPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  iirdf1_in_if.sink    in_i,
  iirdf1_out_if.source out_o
);
  import iirdf1_pkg::*;

  localparam int unsigned HIST = TAPS - 1;
  localparam int unsigned HAW  = (HIST > 1) ? $clog2(HIST) : 1;
  localparam int unsigned CDEP = 2 * TAPS;
  localparam int unsigned CAW  = $clog2(CDEP);
  localparam int unsigned KW   = $clog2(TAPS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_DR1  = 3'd2;
  localparam logic [2:0] ST_DR2  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]    state_d, state_q;
  logic [KW-1:0] k_d, k_q;
  logic          ph_d, ph_q;
  logic [HAW-1:0] head_d, head_q, rdp_d, rdp_q, wrp;
  logic [HIST-1:0] hval_d, hval_q;
  logic [CDEP-1:0] cval_d, cval_q;
  logic          p1_valid_q, cok_q, hok_q;
  opnd_e         p1_opnd_q, opnd_now;
  logic signed [SAMPLE_W-1:0] x_q;
  logic          last_q;
  logic          accept, smp_acc, coef_we, hist_re, done_go, last_step;
  logic [CAW-1:0] c_waddr, c_raddr;
  logic signed [COEF_W-1:0] c_rdata;
  logic [2*SAMPLE_W-1:0] h_rdata;
  mac_ctrl_t     mctrl;
  logic signed [SAMPLE_W-1:0] y;
  logic          sat;
  logic          ov_q;
  logic signed [SAMPLE_W-1:0] oy_q;
  logic          osat_q, olast_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign smp_acc    = accept && (in_i.command == CMD_SAMPLE);
  assign coef_we    = accept && ((in_i.command == CMD_WR_FF) || (in_i.command == CMD_WR_FB))
                      && (32'(in_i.coef_index) < TAPS);
  assign c_waddr    = CAW'(in_i.coef_index)
                      + ((in_i.command == CMD_WR_FB) ? CAW'(TAPS) : CAW'(0));
  assign c_raddr    = ph_q ? CAW'(TAPS) + CAW'(k_q) : CAW'(k_q);
  assign hist_re    = (state_q == ST_RUN) && !ph_q && (k_q != '0);
  assign last_step  = ph_q && (k_q == KW'(TAPS - 1));
  assign done_go    = (state_q == ST_DONE) && (!ov_q || out_o.ready);
  assign wrp        = (head_q == HAW'(HIST - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    if (k_q == '0) begin
      opnd_now = OPND_SAMPLE;
    end else if (ph_q) begin
      opnd_now = OPND_HIST_Y;
    end else begin
      opnd_now = OPND_HIST_X;
    end
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    ph_d    = ph_q;
    rdp_d   = rdp_q;
    head_d  = head_q;
    hval_d  = hval_q;
    cval_d  = cval_q;
    if (coef_we) begin
      cval_d[c_waddr] = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        if (smp_acc) begin
          state_d = ST_RUN;
          k_d     = '0;
          ph_d    = 1'b0;
          rdp_d   = head_q;
        end
      end
      ST_RUN: begin
        if (hist_re) begin
          rdp_d = (rdp_q == '0) ? HAW'(HIST - 1) : rdp_q - 1'b1;
        end
        if (k_q == '0) begin
          k_d = KW'(1);
        end else if (!ph_q) begin
          ph_d = 1'b1;
        end else if (last_step) begin
          state_d = ST_DR1;
        end else begin
          ph_d = 1'b0;
          k_d  = k_q + 1'b1;
        end
      end
      ST_DR1: state_d = ST_DR2;
      ST_DR2: state_d = ST_DONE;
      ST_DONE: begin
        if (done_go) begin
          state_d = ST_IDLE;
          head_d  = wrp;
          if (last_q) begin
            hval_d = '0;
          end else begin
            hval_d[wrp] = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      k_q        <= '0;
      ph_q       <= 1'b0;
      rdp_q      <= '0;
      head_q     <= '0;
      hval_q     <= '0;
      cval_q     <= '0;
      p1_valid_q <= 1'b0;
      p1_opnd_q  <= OPND_SAMPLE;
      cok_q      <= 1'b0;
      hok_q      <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      k_q        <= k_d;
      ph_q       <= ph_d;
      rdp_q      <= rdp_d;
      head_q     <= head_d;
      hval_q     <= hval_d;
      cval_q     <= cval_d;
      p1_valid_q <= (state_q == ST_RUN);
      p1_opnd_q  <= opnd_now;
      cok_q      <= cval_q[c_raddr];
      if (hist_re) begin
        hok_q <= hval_q[rdp_q];
      end
      if (done_go) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      x_q    <= in_i.sample_in;
      last_q <= in_i.block_end;
    end
    if (done_go) begin
      oy_q    <= y;
      osat_q  <= sat;
      olast_q <= last_q;
    end
  end

  iirdf1_ram #(
    .WIDTH (COEF_W),
    .DEPTH (CDEP)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (c_waddr),
    .wdata_i (in_i.coef_value),
    .re_i    (state_q == ST_RUN),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  iirdf1_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (HIST)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (done_go && !last_q),
    .waddr_i (wrp),
    .wdata_i ({x_q, y}),
    .re_i    (hist_re),
    .raddr_i (rdp_q),
    .rdata_o (h_rdata)
  );

  always_comb begin
    mctrl.clear   = smp_acc;
    mctrl.valid   = p1_valid_q;
    mctrl.opnd    = p1_opnd_q;
    mctrl.coef_ok = cok_q;
    mctrl.hist_ok = hok_q;
  end

  iirdf1_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mctrl),
    .coef_i   (c_rdata),
    .sample_i (x_q),
    .hist_x_i (h_rdata[2*SAMPLE_W-1:SAMPLE_W]),
    .hist_y_i (h_rdata[SAMPLE_W-1:0]),
    .y_o      (y),
    .sat_o    (sat)
  );

  assign out_o.valid      = ov_q;
  assign out_o.sample_out = oy_q;
  assign out_o.saturated  = osat_q;
  assign out_o.last_out   = olast_q;

endmodule
